// ===== rtl/legjac_pkg.sv =====
// ----------------------------------------------------------------------------
// legjac_pkg
// Shared types, constants and arithmetic helpers of the leg kinematics block.
// ----------------------------------------------------------------------------
package legjac_pkg;

    // fixed-point formats
    localparam int TRIG_W = 32;   // sine / cosine, 2^-30
    localparam int CX_W   = 33;   // rotation datapath width
    localparam int Z_W    = 34;   // residual angle, 2^-30 rad

    localparam logic signed [CX_W-1:0] CORDIC_K    = 33'sd652032874;
    localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [Z_W-1:0]  PI_Q30      = 34'sd3373259426;

    // Cartesian axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef logic signed [TRIG_W-1:0] trig_t;

    // one item after the trig front end
    typedef struct packed {
        trig_t              s1;
        trig_t              c1;
        trig_t              s2;
        trig_t              c2;
        trig_t              s23;
        trig_t              c23;
        logic signed [15:0] abad_rate;
        logic signed [15:0] hip_rate;
        logic signed [15:0] knee_rate;
        logic               side_pos;
    } legjac_item_t;

    // link lengths as seen by the back end
    typedef struct packed {
        logic [15:0] hip_len;
        logic [15:0] knee_len;
        logic [16:0] lat_len;   // abduction length plus lateral offset
    } legjac_cfg_t;

    // one result row
    typedef struct packed {
        logic [1:0]          axis;
        logic signed [18:0]  jac_abad;
        logic signed [18:0]  jac_hip;
        logic signed [18:0]  jac_knee;
        logic signed [18:0]  foot_position;
        logic signed [23:0]  foot_velocity;
        logic                last;
    } legjac_result_t;

    // truncated atan(2^-i) in 2^-30 rad
    function automatic logic [29:0] atan_q30(input int unsigned idx);
        logic [29:0] v;
        case (idx)
            0:       v = 30'h3243F6A8;
            1:       v = 30'h1DAC6705;
            2:       v = 30'h0FADBAFC;
            3:       v = 30'h07F56EA6;
            4:       v = 30'h03FEAB76;
            5:       v = 30'h01FFD55B;
            6:       v = 30'h00FFFAAA;
            7:       v = 30'h007FFF55;
            8:       v = 30'h003FFFEA;
            9:       v = 30'h001FFFFD;
            10:      v = 30'h000FFFFF;
            11:      v = 30'h0007FFFF;
            12:      v = 30'h0003FFFF;
            13:      v = 30'h0001FFFF;
            14:      v = 30'h0000FFFF;
            15:      v = 30'h00007FFF;
            16:      v = 30'h00003FFF;
            17:      v = 30'h00001FFF;
            18:      v = 30'h00000FFF;
            19:      v = 30'h000007FF;
            20:      v = 30'h000003FF;
            21:      v = 30'h000001FF;
            22:      v = 30'h000000FF;
            23:      v = 30'h0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

    // round half up by 2^30
    function automatic logic signed [32:0] rnd30(input logic signed [64:0] p);
        logic signed [64:0] r;
        r = (p + 65'sd536870912) >>> 30;
        return r[32:0];
    endfunction

    // length sum in 2^-46 to saturated 2^-16
    function automatic logic signed [18:0] sat_len(input logic signed [53:0] acc);
        logic signed [53:0] r;
        logic signed [18:0] q;
        r = (acc + 54'sd536870912) >>> 30;
        if (r > 54'sd262143)
            q = 19'sd262143;
        else if (r < -54'sd262144)
            q = -19'sd262144;
        else
            q = r[18:0];
        return q;
    endfunction

    // velocity sum in 2^-24 to saturated 2^-12
    function automatic logic signed [23:0] sat_vel(input logic signed [36:0] acc);
        logic signed [36:0] r;
        logic signed [23:0] q;
        r = (acc + 37'sd2048) >>> 12;
        if (r > 37'sd8388607)
            q = 24'sd8388607;
        else if (r < -37'sd8388608)
            q = -24'sd8388608;
        else
            q = r[23:0];
        return q;
    endfunction

endpackage

// ===== rtl/legjac_front.sv =====
// ----------------------------------------------------------------------------
// legjac_front
// Accepts requests, runs three pipelined rotation lanes and forms the summed
// hip-knee angle terms; holds credits for the queue behind it.
// ----------------------------------------------------------------------------
module legjac_front #(
    parameter int TRIG_STAGES = 16,
    parameter int QDEPTH      = 9
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [103:0]           in_data,
    input  logic                   pop,
    output logic                   push,
    output legjac_pkg::legjac_item_t push_item
);
    import legjac_pkg::*;

    localparam int CW = $clog2(QDEPTH + 1);

    logic          accept;
    logic [CW-1:0] used_reg;
    logic [CW-1:0] used_next;

    // rotation pipeline, stage 0 holds the folded angles
    logic signed [CX_W-1:0] x_reg    [0:TRIG_STAGES][0:2];
    logic signed [CX_W-1:0] y_reg    [0:TRIG_STAGES][0:2];
    logic signed [Z_W-1:0]  z_reg    [0:TRIG_STAGES][0:2];
    logic                   neg_reg  [0:TRIG_STAGES][0:2];
    logic                   vld_reg  [0:TRIG_STAGES];
    logic [47:0]            rate_reg [0:TRIG_STAGES];
    logic                   side_reg [0:TRIG_STAGES];

    logic signed [Z_W-1:0]  z_in    [0:2];
    logic signed [Z_W-1:0]  z_fold  [0:2];
    logic                   neg_in  [0:2];

    // sign-corrected sines and cosines
    logic                   sc_vld_reg;
    trig_t                  s_reg [0:2];
    trig_t                  c_reg [0:2];
    logic [47:0]            sc_rate_reg;
    logic                   sc_side_reg;

    // angle-sum products
    logic                   pr_vld_reg;
    logic signed [63:0]     p_cc_reg;
    logic signed [63:0]     p_ss_reg;
    logic signed [63:0]     p_sc_reg;
    logic signed [63:0]     p_cs_reg;
    trig_t                  pr_s1_reg;
    trig_t                  pr_c1_reg;
    trig_t                  pr_s2_reg;
    trig_t                  pr_c2_reg;
    logic [47:0]            pr_rate_reg;
    logic                   pr_side_reg;

    logic                   it_vld_reg;
    legjac_item_t           item_reg;
    logic signed [32:0]     c23_w;
    logic signed [32:0]     s23_w;

    // credit count: accepted but not yet taken by the back end
    assign accept    = in_valid & in_ready;
    assign in_ready  = (used_reg < CW'(QDEPTH));
    assign used_next = used_reg + CW'(accept) - CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            used_reg <= '0;
        else
            used_reg <= used_next;
    end

    // widen to 2^-30 and fold into the right half plane
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            z_in[l] = Z_W'($signed(in_data[2 + 16*l +: 16])) <<< 17;
            if (z_in[l] > HALF_PI_Q30)
            begin
                z_fold[l] = z_in[l] - PI_Q30;
                neg_in[l] = 1'b1;
            end
            else if (z_in[l] < -HALF_PI_Q30)
            begin
                z_fold[l] = z_in[l] + PI_Q30;
                neg_in[l] = 1'b1;
            end
            else
            begin
                z_fold[l] = z_in[l];
                neg_in[l] = 1'b0;
            end
        end
    end

    // rotation pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= TRIG_STAGES; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int i = 0; i < TRIG_STAGES; i++)
                vld_reg[i+1] <= vld_reg[i];
        end
    end

    // stage 0 payload, then one micro-rotation per stage
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 3; l++)
        begin
            x_reg[0][l]   <= CORDIC_K;
            y_reg[0][l]   <= '0;
            z_reg[0][l]   <= z_fold[l];
            neg_reg[0][l] <= neg_in[l];
        end
        rate_reg[0] <= in_data[97:50];
        side_reg[0] <= in_data[0];

        for (int i = 0; i < TRIG_STAGES; i++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                if (z_reg[i][l] >= 0)
                begin
                    x_reg[i+1][l] <= x_reg[i][l] - (y_reg[i][l] >>> i);
                    y_reg[i+1][l] <= y_reg[i][l] + (x_reg[i][l] >>> i);
                    z_reg[i+1][l] <= z_reg[i][l] - $signed({4'b0, atan_q30(i)});
                end
                else
                begin
                    x_reg[i+1][l] <= x_reg[i][l] + (y_reg[i][l] >>> i);
                    y_reg[i+1][l] <= y_reg[i][l] - (x_reg[i][l] >>> i);
                    z_reg[i+1][l] <= z_reg[i][l] + $signed({4'b0, atan_q30(i)});
                end
                neg_reg[i+1][l] <= neg_reg[i][l];
            end
            rate_reg[i+1] <= rate_reg[i];
            side_reg[i+1] <= side_reg[i];
        end
    end

    // sum-angle terms, rounded
    assign c23_w = rnd30(65'(p_cc_reg) - 65'(p_ss_reg));
    assign s23_w = rnd30(65'(p_sc_reg) + 65'(p_cs_reg));

    // tail valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_vld_reg <= 1'b0;
            pr_vld_reg <= 1'b0;
            it_vld_reg <= 1'b0;
        end
        else
        begin
            sc_vld_reg <= vld_reg[TRIG_STAGES];
            pr_vld_reg <= sc_vld_reg;
            it_vld_reg <= pr_vld_reg;
        end
    end

    // undo the fold, multiply, then sum
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 3; l++)
        begin
            s_reg[l] <= neg_reg[TRIG_STAGES][l] ? trig_t'(-y_reg[TRIG_STAGES][l])
                                                : trig_t'(y_reg[TRIG_STAGES][l]);
            c_reg[l] <= neg_reg[TRIG_STAGES][l] ? trig_t'(-x_reg[TRIG_STAGES][l])
                                                : trig_t'(x_reg[TRIG_STAGES][l]);
        end
        sc_rate_reg <= rate_reg[TRIG_STAGES];
        sc_side_reg <= side_reg[TRIG_STAGES];

        p_cc_reg    <= c_reg[1] * c_reg[2];
        p_ss_reg    <= s_reg[1] * s_reg[2];
        p_sc_reg    <= s_reg[1] * c_reg[2];
        p_cs_reg    <= c_reg[1] * s_reg[2];
        pr_s1_reg   <= s_reg[0];
        pr_c1_reg   <= c_reg[0];
        pr_s2_reg   <= s_reg[1];
        pr_c2_reg   <= c_reg[1];
        pr_rate_reg <= sc_rate_reg;
        pr_side_reg <= sc_side_reg;

        item_reg.s1        <= pr_s1_reg;
        item_reg.c1        <= pr_c1_reg;
        item_reg.s2        <= pr_s2_reg;
        item_reg.c2        <= pr_c2_reg;
        item_reg.s23       <= trig_t'(s23_w);
        item_reg.c23       <= trig_t'(c23_w);
        item_reg.abad_rate <= $signed(pr_rate_reg[15:0]);
        item_reg.hip_rate  <= $signed(pr_rate_reg[31:16]);
        item_reg.knee_rate <= $signed(pr_rate_reg[47:32]);
        item_reg.side_pos  <= pr_side_reg;
    end

    assign push      = it_vld_reg;
    assign push_item = item_reg;

endmodule

// ===== rtl/legjac_queue.sv =====
// ----------------------------------------------------------------------------
// legjac_queue
// Short queue between front and back end with a registered head entry.
// ----------------------------------------------------------------------------
module legjac_queue #(
    parameter int QDEPTH = 9
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  legjac_pkg::legjac_item_t push_item,
    input  logic                     pop,
    output logic                     head_valid,
    output legjac_pkg::legjac_item_t head_item
);
    import legjac_pkg::*;

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    legjac_item_t  mem [0:QDEPTH-1];
    legjac_item_t  head_reg;
    logic          head_vld_reg;
    logic          head_vld_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] wr_ptr_reg;
    logic          load;
    logic          from_mem;
    logic          bypass;
    logic          wr;

    // head refill: from storage first, else straight from the front end
    assign load          = ~head_vld_reg | pop;
    assign from_mem      = load & (cnt_reg != '0);
    assign bypass        = load & (cnt_reg == '0) & push;
    assign wr            = push & ~bypass;
    assign head_vld_next = load ? (from_mem | push) : 1'b1;
    assign cnt_next      = cnt_reg + CW'(wr) - CW'(from_mem);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg <= 1'b0;
            cnt_reg      <= '0;
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
        end
        else
        begin
            head_vld_reg <= head_vld_next;
            cnt_reg      <= cnt_next;
            if (wr)
                wr_ptr_reg <= (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (from_mem)
                rd_ptr_reg <= (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    // storage and head data
    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wr_ptr_reg] <= push_item;
        if (from_mem)
            head_reg <= mem[rd_ptr_reg];
        else if (bypass)
            head_reg <= push_item;
    end

    assign head_valid = head_vld_reg;
    assign head_item  = head_reg;

endmodule

// ===== rtl/legjac_back.sv =====
// ----------------------------------------------------------------------------
// legjac_back
// Issues the three axis rows of one item, one row per cycle while the output
// is not held, through a shared multiply pipeline and a registered output.
// ----------------------------------------------------------------------------
module legjac_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  legjac_pkg::legjac_cfg_t    cfg,
    input  logic                       q_valid,
    input  legjac_pkg::legjac_item_t   q_item,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output legjac_pkg::legjac_result_t out_result
);
    import legjac_pkg::*;

    logic en;
    logic take;

    // issue stage
    logic         busy_reg;
    logic [1:0]   row_reg;
    legjac_item_t cur_reg;

    // stage 1: trig products
    trig_t              fj;
    trig_t              fh;
    trig_t              fp;
    logic               v1_reg;
    logic [1:0]         row1_reg;
    logic signed [63:0] pja_reg, pjb_reg, pha_reg, phb_reg, ppa_reg, ppb_reg;
    logic signed [32:0] w0_reg, wp_reg;
    logic               negh1_reg, negp1_reg;
    logic signed [17:0] lat1_reg;
    logic signed [15:0] r1_reg [0:2];

    // stage 2: rounded trig terms
    logic               v2_reg;
    logic [1:0]         row2_reg;
    logic signed [32:0] gja_reg, gjb_reg, gha_reg, ghb_reg, gpa_reg, gpb_reg;
    logic signed [32:0] w02_reg, wp2_reg;
    logic signed [17:0] lat2_reg;
    logic signed [15:0] r2_reg [0:2];
    logic signed [32:0] gha_w, ghb_w, gpa_w, gpb_w;

    // stage 3: length products
    logic signed [16:0] l2s;
    logic signed [16:0] l3s;
    logic               v3_reg;
    logic [1:0]         row3_reg;
    logic signed [50:0] tja_reg, tjb_reg, tjw_reg, tha_reg, thb_reg;
    logic signed [50:0] tpa_reg, tpb_reg, tpw_reg;
    logic signed [15:0] r3_reg [0:2];

    // stage 4: saturated row
    logic               v4_reg;
    logic [1:0]         row4_reg;
    logic signed [18:0] j0_reg, j1_reg, j2_reg, pos4_reg;
    logic signed [15:0] r4_reg [0:2];

    // stage 5: rate products
    logic               v5_reg;
    logic [1:0]         row5_reg;
    logic signed [18:0] j05_reg, j15_reg, j25_reg, pos5_reg;
    logic signed [34:0] m0_reg, m1_reg, m2_reg;

    // output register
    logic               o_vld_reg;
    legjac_result_t     o_reg;

    // whole back end moves together unless the output is held
    assign en   = ~o_vld_reg | out_ready;
    assign take = en & (~busy_reg | (row_reg == AXIS_Z));
    assign pop  = take & q_valid;

    // row sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            row_reg  <= AXIS_X;
        end
        else if (take)
        begin
            busy_reg <= q_valid;
            row_reg  <= AXIS_X;
        end
        else if (en)
        begin
            row_reg <= row_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= q_item;
    end

    // per-row trig factors
    always_comb
    begin
        case (row_reg)
            AXIS_Y:
            begin
                fj = cur_reg.c1;
                fh = cur_reg.s1;
                fp = cur_reg.s1;
            end
            default:
            begin
                fj = cur_reg.s1;
                fh = cur_reg.c1;
                fp = cur_reg.c1;
            end
        endcase
    end

    assign gha_w = negh1_reg ? -rnd30(65'(pha_reg)) : rnd30(65'(pha_reg));
    assign ghb_w = negh1_reg ? -rnd30(65'(phb_reg)) : rnd30(65'(phb_reg));
    assign gpa_w = negp1_reg ? -rnd30(65'(ppa_reg)) : rnd30(65'(ppa_reg));
    assign gpb_w = negp1_reg ? -rnd30(65'(ppb_reg)) : rnd30(65'(ppb_reg));

    assign l2s = $signed({1'b0, cfg.hip_len});
    assign l3s = $signed({1'b0, cfg.knee_len});

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= busy_reg;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            o_vld_reg <= v5_reg;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: x row passes raw trig values scaled up
            row1_reg <= row_reg;
            if (row_reg == AXIS_X)
            begin
                pja_reg <= '0;
                pjb_reg <= '0;
                pha_reg <= 64'(cur_reg.c23) <<< 30;
                phb_reg <= 64'(cur_reg.c2) <<< 30;
                ppa_reg <= 64'(cur_reg.s23) <<< 30;
                ppb_reg <= 64'(cur_reg.s2) <<< 30;
                w0_reg  <= '0;
                wp_reg  <= '0;
            end
            else
            begin
                pja_reg <= fj * cur_reg.c23;
                pjb_reg <= fj * cur_reg.c2;
                pha_reg <= fh * cur_reg.s23;
                phb_reg <= fh * cur_reg.s2;
                ppa_reg <= fp * cur_reg.c23;
                ppb_reg <= fp * cur_reg.c2;
                w0_reg  <= (row_reg == AXIS_Y) ? -33'(cur_reg.s1) : 33'(cur_reg.c1);
                wp_reg  <= (row_reg == AXIS_Y) ? 33'(cur_reg.c1) : 33'(cur_reg.s1);
            end
            negh1_reg <= (row_reg == AXIS_Y);
            negp1_reg <= (row_reg == AXIS_Z);
            lat1_reg  <= cur_reg.side_pos ? $signed({1'b0, cfg.lat_len})
                                          : -$signed({1'b0, cfg.lat_len});
            r1_reg[0] <= cur_reg.abad_rate;
            r1_reg[1] <= cur_reg.hip_rate;
            r1_reg[2] <= cur_reg.knee_rate;

            // stage 2: round back to 2^-30
            row2_reg <= row1_reg;
            gja_reg  <= rnd30(65'(pja_reg));
            gjb_reg  <= rnd30(65'(pjb_reg));
            gha_reg  <= gha_w;
            ghb_reg  <= ghb_w;
            gpa_reg  <= gpa_w;
            gpb_reg  <= gpb_w;
            w02_reg  <= w0_reg;
            wp2_reg  <= wp_reg;
            lat2_reg <= lat1_reg;
            r2_reg   <= r1_reg;

            // stage 3: times link lengths
            row3_reg <= row2_reg;
            tja_reg  <= l3s * gja_reg;
            tjb_reg  <= l2s * gjb_reg;
            tjw_reg  <= lat2_reg * w02_reg;
            tha_reg  <= l3s * gha_reg;
            thb_reg  <= l2s * ghb_reg;
            tpa_reg  <= l3s * gpa_reg;
            tpb_reg  <= l2s * gpb_reg;
            tpw_reg  <= lat2_reg * wp2_reg;
            r3_reg   <= r2_reg;

            // stage 4: sum, round, saturate
            row4_reg <= row3_reg;
            j0_reg   <= sat_len(54'(tja_reg) + 54'(tjb_reg) + 54'(tjw_reg));
            j1_reg   <= sat_len(54'(tha_reg) + 54'(thb_reg));
            j2_reg   <= sat_len(54'(tha_reg));
            pos4_reg <= sat_len(54'(tpa_reg) + 54'(tpb_reg) + 54'(tpw_reg));
            r4_reg   <= r3_reg;

            // stage 5: times joint rates
            row5_reg <= row4_reg;
            j05_reg  <= j0_reg;
            j15_reg  <= j1_reg;
            j25_reg  <= j2_reg;
            pos5_reg <= pos4_reg;
            m0_reg   <= j0_reg * r4_reg[0];
            m1_reg   <= j1_reg * r4_reg[1];
            m2_reg   <= j2_reg * r4_reg[2];

            // output register
            o_reg.axis          <= row5_reg;
            o_reg.jac_abad      <= j05_reg;
            o_reg.jac_hip       <= j15_reg;
            o_reg.jac_knee      <= j25_reg;
            o_reg.foot_position <= pos5_reg;
            o_reg.foot_velocity <= sat_vel(37'(m0_reg) + 37'(m1_reg) + 37'(m2_reg));
            o_reg.last          <= (row5_reg == AXIS_Z);
        end
    end

    assign out_valid  = o_vld_reg;
    assign out_result = o_reg;

endmodule

// ===== rtl/leg_jacobian_and_foot_kinematics.sv =====
// An accepted request passes the rotation stages, the front-end tail, the queue
// and the back-end stages before its x result; y and z follow in order.
// The back end issues one axis row per cycle through its shared multipliers
// while the output is not held, and takes the next request as the z row issues.
// Reset clears all valid bits, credits and the link length registers to
// zero; there is no clearing pass.
// ----------------------------------------------------------------------------
// leg_jacobian_and_foot_kinematics
// Three-joint leg Jacobian, foot position and foot velocity per request.
// ----------------------------------------------------------------------------
module leg_jacobian_and_foot_kinematics #(
    parameter int TRIG_STAGES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // configuration writes
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [15:0]  cfg_data,
    // request stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // leg_index, abad_angle, hip_angle, knee_angle, abad_rate, hip_rate,
    // knee_rate, zero fill
    input  logic [103:0] s_axis_tdata,
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // axis, jac_abad, jac_hip, jac_knee, foot_position, foot_velocity,
    // zero fill
    output logic [103:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    import legjac_pkg::*;

    localparam int QDEPTH = (TRIG_STAGES + 9) / 3 + 1;

    localparam logic [1:0] REG_ABAD_LEN = 2'd0;
    localparam logic [1:0] REG_HIP_LEN  = 2'd1;
    localparam logic [1:0] REG_KNEE_LEN = 2'd2;
    localparam logic [1:0] REG_LAT_OFS  = 2'd3;

    logic [15:0]    abad_len_reg;
    logic [15:0]    hip_len_reg;
    logic [15:0]    knee_len_reg;
    logic [15:0]    lat_ofs_reg;
    legjac_cfg_t    cfg;

    logic           pop;
    logic           push;
    legjac_item_t   push_item;
    logic           head_valid;
    legjac_item_t   head_item;
    legjac_result_t res;

    // link length registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abad_len_reg <= '0;
            hip_len_reg  <= '0;
            knee_len_reg <= '0;
            lat_ofs_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_ABAD_LEN: abad_len_reg <= cfg_data;
                REG_HIP_LEN:  hip_len_reg  <= cfg_data;
                REG_KNEE_LEN: knee_len_reg <= cfg_data;
                REG_LAT_OFS:  lat_ofs_reg  <= cfg_data;
                default:      lat_ofs_reg  <= lat_ofs_reg;
            endcase
        end
    end

    assign cfg.hip_len  = hip_len_reg;
    assign cfg.knee_len = knee_len_reg;
    assign cfg.lat_len  = {1'b0, abad_len_reg} + {1'b0, lat_ofs_reg};

    legjac_front #(
        .TRIG_STAGES (TRIG_STAGES),
        .QDEPTH      (QDEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .pop       (pop),
        .push      (push),
        .push_item (push_item)
    );

    legjac_queue #(
        .QDEPTH (QDEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    legjac_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_valid    (head_valid),
        .q_item     (head_item),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (res)
    );

    // result packing
    assign m_axis_tdata = {2'b00, res.foot_velocity, res.foot_position, res.jac_knee,
                           res.jac_hip, res.jac_abad, res.axis};
    assign m_axis_tlast = res.last;

endmodule

// ===== rtl/legjac_checker.sv =====
// ----------------------------------------------------------------------------
// legjac_checker
// Port-level checks on the result stream of the leg kinematics block.
// ----------------------------------------------------------------------------
module legjac_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata,
    input logic         m_axis_tlast
);
    import legjac_pkg::*;

    // a held result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while held");

    // last marks the z row and only it
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[1:0] == AXIS_Z)))
        else $error("last flag does not match axis");

    // x row has no abduction dependence
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] == AXIS_X) |-> (m_axis_tdata[20:2] == '0))
        else $error("x row abduction entry not zero");

    // no result right out of reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind leg_jacobian_and_foot_kinematics legjac_checker u_legjac_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
